### sv/lobm_pkg.sv
// Package: book sizes, entry layout and modulus for the order book matcher.
`default_nettype none
package lobm_pkg;
  localparam int BookDepth = 64;
  localparam int IdxW = $clog2(BookDepth);
  localparam int CntW = $clog2(BookDepth + 1);
  localparam int SumW = 39;
  localparam logic [29:0] BacklogMod = 30'd1000000007;

  typedef logic [63:0] entry_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
endpackage
`default_nettype wire

### sv/lobm_book.sv
// One side of the book: entry memory with one write port and one registered read port.
`default_nettype none
module lobm_book (
  input  wire              clk,
  input  wire              wr_en,
  input  lobm_pkg::idx_t   wr_addr,
  input  lobm_pkg::entry_t wr_data,
  input  lobm_pkg::idx_t   rd_addr,
  output lobm_pkg::entry_t rd_data
);
  import lobm_pkg::*;

  entry_t mem [BookDepth];

  // Synchronous write, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### sv/lobm_mod.sv
// Reduction of the running sum modulo 1e9+7 by folding the upper bits, then one final subtract.
`default_nettype none
module lobm_mod (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        go,
  input  wire [lobm_pkg::SumW-1:0]   sum,
  output logic                       done,
  output logic [29:0]                rem
);
  import lobm_pkg::*;

  // 2^30 mod (1e9+7); a value hi * 2^30 + lo is congruent to hi * FoldK + lo
  localparam logic [26:0] FoldK = 27'd73741817;
  // Three folds bring any 39-bit value below 2 * modulus
  localparam int Folds = 3;
  localparam int StW = $clog2(Folds + 1);

  logic [SumW-1:0] work;
  logic [StW-1:0]  step;
  logic            active;
  logic [35:0]     prod;
  logic [SumW-1:0] folded;

  // One fold: upper 9 bits times the constant, added to the lower 30 bits
  assign prod   = 36'(work[SumW-1:30]) * 36'(FoldK);
  assign folded = {{(SumW-30){1'b0}}, work[29:0]} + SumW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        work   <= sum;
        step   <= StW'(Folds);
      end else if (active) begin
        if (step != '0) begin
          work <= folded;
          step <= step - StW'(1);
        end else begin
          // Value is below 2 * modulus here
          if (work >= SumW'(BacklogMod)) begin
            work <= work - SumW'(BacklogMod);
          end
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rem = work[29:0];
endmodule
`default_nettype wire

### sv/limit_order_book_matcher_core.sv
// Top level: sequencer that scans the opposite book, matches, rests and reports.
//
//  channel  | signals                                     | handshake
//  order    | order_price, order_amount, order_side       | start & !busy
//  result   | traded_amount, rested_amount, book_full,    | strobe, one cycle
//           | backlog_total                               |
//
// A match pass streams the opposite entries through the registered read port and
// compares them, then moves the last entry into a consumed slot or updates a
// partial fill. The closing pass ends on no cross or is skipped if nothing can
// match; rest and modulo follow, and strobe is registered when modulo is done.
// Reset empties both books at once (counts only). The result cannot be stalled.
`default_nettype none
module limit_order_book_matcher_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [31:0] order_price,
  input  wire  [31:0] order_amount,
  input  wire         order_side,
  output logic        strobe,
  output logic [31:0] traded_amount,
  output logic [31:0] rested_amount,
  output logic        book_full,
  output logic [29:0] backlog_total
);
  import lobm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WAIT, S_EVAL, S_LAST, S_LASTW, S_REST, S_MOD, S_DONE
  } state_t;

  state_t state;
  logic [31:0] price, amount, traded;
  logic        side, full;
  cnt_t        buy_used, sell_used;
  logic [SumW-1:0] resting_sum;
  idx_t rd_addr, best_idx;
  cnt_t scan;
  logic scan_v, have_best;
  entry_t best;
  logic [31:0] rested;

  // Book memories
  logic   wr_b, wr_s;
  idx_t   wr_addr;
  entry_t wr_data, rd_b, rd_s, rd;
  lobm_book u_buy (.clk, .wr_en(wr_b), .wr_addr, .wr_data, .rd_addr, .rd_data(rd_b));
  lobm_book u_sell(.clk, .wr_en(wr_s), .wr_addr, .wr_data, .rd_addr, .rd_data(rd_s));
  assign rd = side ? rd_b : rd_s;

  // Modulo unit
  logic mod_go, mod_done;
  logic [29:0] mod_rem;
  lobm_mod u_mod (.clk, .rst, .go(mod_go), .sum(resting_sum), .done(mod_done), .rem(mod_rem));

  cnt_t opp_used, own_used;
  assign opp_used = side ? buy_used : sell_used;
  assign own_used = side ? sell_used : buy_used;

  logic better, crosses;
  logic [31:0] e_amt, m;
  assign better  = !have_best || (side ? (rd > best) : (rd < best));
  assign crosses = side ? (best[63:32] >= price) : (best[63:32] <= price);
  assign e_amt   = best[31:0];
  assign m       = (amount < e_amt) ? amount : e_amt;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      buy_used <= '0;
      sell_used <= '0;
      resting_sum <= '0;
      strobe <= 1'b0;
      wr_b <= 1'b0;
      wr_s <= 1'b0;
      mod_go <= 1'b0;
    end else begin
      strobe <= 1'b0;
      wr_b <= 1'b0;
      wr_s <= 1'b0;
      mod_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            price <= order_price;
            amount <= order_amount;
            side <= order_side;
            traded <= '0;
            full <= 1'b0;
            rested <= '0;
            state <= S_SCAN;
          end
        end
        // Start a scan pass if there is work
        S_SCAN: begin
          if (amount == '0 || opp_used == '0) begin
            state <= S_REST;
          end else begin
            rd_addr <= '0;
            scan <= '0;
            scan_v <= 1'b0;
            have_best <= 1'b0;
            state <= S_WAIT;
          end
        end
        // Stream entries: each address passes rd_addr and the read register before compare
        S_WAIT: begin
          if (scan_v && better) begin
            best <= rd;
            best_idx <= idx_t'(scan - cnt_t'(1));
            have_best <= 1'b1;
          end
          if (scan == opp_used) begin
            if (scan_v) begin
              state <= S_EVAL;
            end
            scan_v <= 1'b0;
          end else begin
            scan_v <= 1'b1;
            rd_addr <= idx_t'(scan + cnt_t'(1));
            scan <= scan + cnt_t'(1);
          end
          if (scan == opp_used && !scan_v) begin
            state <= S_EVAL;
          end
        end
        // Match against best entry
        S_EVAL: begin
          if (!crosses) begin
            state <= S_REST;
          end else begin
            amount <= amount - m;
            traded <= traded + m;
            resting_sum <= resting_sum - SumW'(m);
            if (e_amt == m) begin
              rd_addr <= idx_t'(opp_used - cnt_t'(1));
              if (side) buy_used <= buy_used - cnt_t'(1);
              else      sell_used <= sell_used - cnt_t'(1);
              state <= S_LAST;
            end else begin
              wr_addr <= best_idx;
              wr_data <= {best[63:32], e_amt - m};
              wr_b <= side;
              wr_s <= !side;
              state <= S_LASTW;
            end
          end
        end
        S_LAST: state <= S_LASTW;
        // Move last entry into the hole (or finish partial update)
        S_LASTW: begin
          if (!(wr_b || wr_s)) begin
            wr_addr <= best_idx;
            wr_data <= rd;
            wr_b <= side;
            wr_s <= !side;
          end
          state <= S_SCAN;
        end
        // Rest the remainder in the own book
        S_REST: begin
          if (amount != '0) begin
            if (own_used >= cnt_t'(BookDepth)) begin
              full <= 1'b1;
            end else begin
              wr_addr <= idx_t'(own_used);
              wr_data <= {price, amount};
              wr_b <= !side;
              wr_s <= side;
              if (side) sell_used <= sell_used + cnt_t'(1);
              else      buy_used <= buy_used + cnt_t'(1);
              resting_sum <= resting_sum + SumW'(amount);
              rested <= amount;
            end
          end
          state <= S_MOD;
        end
        S_MOD: begin
          mod_go <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (mod_done) begin
            strobe <= 1'b1;
            traded_amount <= traded;
            rested_amount <= rested;
            book_full <= full;
            backlog_total <= mod_rem;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### tb/sv/tb_limit_order_book_matcher_core.sv
// Testbench for the limit order book matcher: random orders, inline book model, strobe checks.
`default_nettype none
module tb_limit_order_book_matcher_core;
  import lobm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] amount;
    logic        side;
  } order_t;

  typedef struct packed {
    logic [31:0] traded;
    logic [31:0] rested;
    logic        full;
    logic [29:0] backlog;
  } fill_t;

  localparam logic SideBuy = 1'b0;
  localparam logic SideSell = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [31:0] order_price = '0;
  logic [31:0] order_amount = '0;
  logic order_side = 1'b0;
  logic busy, strobe, book_full;
  logic [31:0] traded_amount, rested_amount;
  logic [29:0] backlog_total;

  limit_order_book_matcher_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .order_price(order_price), .order_amount(order_amount), .order_side(order_side),
    .strobe(strobe), .traded_amount(traded_amount), .rested_amount(rested_amount),
    .book_full(book_full), .backlog_total(backlog_total)
  );

  always #5 clk = ~clk;

  order_t pending_orders[$];
  fill_t expected_fills[$];
  int errors = 0;
  bit stim_done = 0;
  int sent = 0;

  // Book model state
  logic [63:0] bids[BookDepth];
  logic [63:0] asks[BookDepth];
  int n_bids = 0;
  int n_asks = 0;
  logic [SumW-1:0] resting = '0;

  function automatic fill_t match_order(order_t o);
    fill_t r;
    logic [31:0] left, ep, ea, m;
    int best, i;
    bit go;
    r = '0;
    left = o.amount;
    go = 1;
    while (go && left != 0) begin
      if (o.side == SideSell) begin
        if (n_bids == 0) break;
        best = 0;
        for (i = 1; i < n_bids; i++) if (bids[i] > bids[best]) best = i;
        ep = bids[best][63:32];
        ea = bids[best][31:0];
        if (ep < o.price) break;
      end else begin
        if (n_asks == 0) break;
        best = 0;
        for (i = 1; i < n_asks; i++) if (asks[i] < asks[best]) best = i;
        ep = asks[best][63:32];
        ea = asks[best][31:0];
        if (ep > o.price) break;
      end
      m = (left < ea) ? left : ea;
      left -= m;
      ea -= m;
      r.traded += m;
      resting -= m;
      // Consumed entry is replaced by the last one
      if (o.side == SideSell) begin
        if (ea == 0) begin
          n_bids--;
          bids[best] = bids[n_bids];
        end else bids[best] = {ep, ea};
      end else begin
        if (ea == 0) begin
          n_asks--;
          asks[best] = asks[n_asks];
        end else asks[best] = {ep, ea};
      end
    end
    if (left != 0) begin
      if (o.side == SideSell) begin
        if (n_asks >= BookDepth) r.full = 1;
        else begin
          asks[n_asks] = {o.price, left};
          n_asks++;
        end
      end else begin
        if (n_bids >= BookDepth) r.full = 1;
        else begin
          bids[n_bids] = {o.price, left};
          n_bids++;
        end
      end
      if (!r.full) begin
        resting += left;
        r.rested = left;
      end
    end
    r.backlog = 30'(resting % 39'(BacklogMod));
    return r;
  endfunction

  function automatic order_t pick_order();
    order_t o;
    int mode;
    o.side = 1'($urandom_range(0, 1));
    mode = $urandom_range(0, 99);
    // Mostly prices near a center so books cross often
    if (mode < 70) o.price = 32'd1000 + $urandom_range(0, 40) - 32'd20;
    else if (mode < 80) o.price = $urandom;
    else if (mode < 90) o.price = 32'hFFFF_FFFF - $urandom_range(0, 3);
    else o.price = $urandom_range(0, 3);
    mode = $urandom_range(0, 99);
    if (mode < 70) o.amount = $urandom_range(1, 200);
    else if (mode < 85) o.amount = $urandom;
    else if (mode < 95) o.amount = 32'hFFFF_FFFF - $urandom_range(0, 5);
    else o.amount = $urandom_range(0, 2);
    return o;
  endfunction

  // Idle pattern: none in a quiet stretch, else about 20 percent
  function automatic bit idle_now();
    if (sent >= 250 && sent < 400) return 0;
    return $urandom_range(0, 99) < 20;
  endfunction

  // Driver
  always @(posedge clk) begin
    if (rst) start <= 1'b0;
    else begin
      if (start && !busy) sent <= sent + 1;
      if (!(start && busy)) begin
        if (pending_orders.size() != 0 && !idle_now()) begin
          order_t o;
          o = pending_orders.pop_front();
          order_price <= o.price;
          order_amount <= o.amount;
          order_side <= o.side;
          expected_fills.push_back(match_order(o));
          start <= 1'b1;
        end else start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_fills.size() == 0) begin
        $display("%0t: unexpected result traded=%0d rested=%0d", $time,
                 traded_amount, rested_amount);
        errors++;
      end else begin
        fill_t e;
        e = expected_fills.pop_front();
        if (traded_amount !== e.traded) begin
          $display("%0t: traded exp %0d got %0d", $time, e.traded, traded_amount);
          errors++;
        end
        if (rested_amount !== e.rested) begin
          $display("%0t: rested exp %0d got %0d", $time, e.rested, rested_amount);
          errors++;
        end
        if (book_full !== e.full) begin
          $display("%0t: book_full exp %0d got %0d", $time, e.full, book_full);
          errors++;
        end
        if (backlog_total !== e.backlog) begin
          $display("%0t: backlog exp %0d got %0d", $time, e.backlog, backlog_total);
          errors++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    order_t o;
    int i;
    // Directed: zero amount, extremes, ties, cross both ways
    pending_orders.push_back('{price: 32'd100, amount: 32'd0, side: SideBuy});
    pending_orders.push_back('{price: 32'd100, amount: 32'd10, side: SideBuy});
    pending_orders.push_back('{price: 32'd100, amount: 32'd30, side: SideBuy});
    pending_orders.push_back('{price: 32'd100, amount: 32'd20, side: SideBuy});
    pending_orders.push_back('{price: 32'd90, amount: 32'd25, side: SideSell});
    pending_orders.push_back('{price: 32'd110, amount: 32'd5, side: SideSell});
    pending_orders.push_back('{price: 32'd110, amount: 32'd3, side: SideSell});
    pending_orders.push_back('{price: 32'd120, amount: 32'd4, side: SideBuy});
    pending_orders.push_back('{price: 32'd0, amount: 32'hFFFF_FFFF, side: SideSell});
    pending_orders.push_back('{price: 32'hFFFF_FFFF, amount: 32'hFFFF_FFFF, side: SideBuy});
    pending_orders.push_back('{price: 32'hFFFF_FFFF, amount: 32'hFFFF_FFFF, side: SideSell});
    pending_orders.push_back('{price: 32'h0, amount: 32'h1, side: SideBuy});
    pending_orders.push_back('{price: 32'h5555_5555, amount: 32'hAAAA_AAAA, side: SideBuy});
    pending_orders.push_back('{price: 32'hAAAA_AAAA, amount: 32'h5555_5555, side: SideSell});
    pending_orders.push_back('{price: 32'd0, amount: 32'd0, side: SideSell});
    // Fill the buy book past its depth to hit the full case
    for (i = 0; i < BookDepth + 3; i++)
      pending_orders.push_back('{price: 32'd1, amount: 32'(i + 1), side: SideBuy});
    // Sweep part of it with a big sell
    pending_orders.push_back('{price: 32'd0, amount: 32'd500, side: SideSell});
    for (i = 0; i < 550; i++) begin
      o = pick_order();
      pending_orders.push_back(o);
    end
    // Fill the sell book past its depth as well
    for (i = 0; i < BookDepth + 3; i++)
      pending_orders.push_back('{price: 32'hFFFF_FFF0, amount: 32'd7, side: SideSell});
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_orders.size() == 0);
    @(posedge clk);
    while (start || busy || expected_fills.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_fills.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
sv/lobm_pkg.sv
sv/lobm_book.sv
sv/lobm_mod.sv
sv/limit_order_book_matcher_core.sv
tb/sv/tb_limit_order_book_matcher_core.sv
